[hw/rtl/dasm_pkg.sv]
// Shared types and constants for the dual actuator sync and stall monitor.
// Holds error and command codes, register indexes and the configuration struct.
// No dependencies.
package dasm_pkg;

  localparam int POT_FULL_SCALE_DEF = 1024;
  localparam int SPEED_BITS_DEF     = 16;

  localparam int POT_W      = 12;
  localparam int CMD_W      = 2;
  localparam int ERR_W      = 3;
  localparam int CNT_W      = 3;
  localparam int THR_W      = 10;
  localparam int WIN_W      = 8;
  localparam int MARGIN_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int HIGH_END_LEVEL  = 800;
  localparam int LOW_END_LEVEL   = 200;
  localparam int NINE_TENTHS_Q15 = 29491;
  localparam int Q15_SHIFT       = 15;

  localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_SYNC  = 3'd1,
    ERR_STILL = 3'd2,
    ERR_POT   = 3'd3,
    ERR_LINK  = 3'd4
  } err_code_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_POT      = 2'd0,
    CMD_SHOULDER = 2'd1,
    CMD_DUMP     = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO       = 3'd0,
    CFG_THR_SMALL  = 3'd1,
    CFG_THR_MID    = 3'd2,
    CFG_THR_LARGE  = 3'd3,
    CFG_STALL_WIN  = 3'd4,
    CFG_CNT_LIMIT  = 3'd5,
    CFG_END_MARGIN = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                auto_en;
    logic [THR_W-1:0]    thr_small;
    logic [THR_W-1:0]    thr_mid;
    logic [THR_W-1:0]    thr_large;
    logic [WIN_W-1:0]    stall_win;
    logic [CNT_W-1:0]    cnt_limit;
    logic [MARGIN_W-1:0] end_margin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    auto_en:    1'b0,
    thr_small:  10'd60,
    thr_mid:    10'd120,
    thr_large:  10'd180,
    stall_win:  8'd10,
    cnt_limit:  3'd5,
    end_margin: 8'd20
  };

  // Per-actuator status kept next to the position history.
  typedef struct packed {
    logic [CNT_W-1:0] still_cnt;
    err_code_t        err;
    logic             at_max;
    logic             at_min;
  } trk_stat_t;

endpackage

[hw/rtl/dasm_track.sv]
// Position tracking for one actuator: extremes, still counter, end stops.
// Purely combinational next-state logic; uses dasm_pkg.
module dasm_track
  import dasm_pkg::*;
#(
  parameter int POS_W      = 10,
  parameter int CMP_W      = 14,
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  cfg_t                          cfg_i,
  input  logic        [POS_W-1:0]       pos_i,
  input  logic signed [SPEED_BITS-1:0]  speed_i,
  input  logic        [POS_W-1:0]       last_i,
  input  logic        [POS_W:0]         low_i,
  input  logic        [POS_W:0]         high_i,
  input  trk_stat_t                     stat_i,
  output logic        [POS_W:0]         low_o,
  output logic        [POS_W:0]         high_o,
  output trk_stat_t                     stat_o
);

  logic [POS_W:0]   pos_w;
  logic [POS_W:0]   low_n;
  logic [POS_W:0]   high_n;
  logic [CMP_W-1:0] p_x;
  logic [CMP_W-1:0] pos_delta;
  logic [CMP_W-1:0] margin_x;
  logic [CNT_W-1:0] cnt_inc;
  logic             sp_neg;
  logic             sp_pos;
  logic             moving;
  logic             hit_max;
  logic             hit_min;

  assign pos_w     = (POS_W+1)'(pos_i);
  assign low_n     = (pos_w < low_i) ? pos_w : low_i;
  assign high_n    = (pos_w > high_i) ? pos_w : high_i;
  assign p_x       = CMP_W'(pos_i);
  assign pos_delta = CMP_W'((pos_i >= last_i) ? (pos_i - last_i) : (last_i - pos_i));
  assign margin_x  = CMP_W'(cfg_i.end_margin);
  assign cnt_inc   = (stat_i.still_cnt == COUNT_MAX) ? stat_i.still_cnt
                                                     : stat_i.still_cnt + 1'b1;

  assign sp_neg = speed_i[SPEED_BITS-1];
  assign moving = |speed_i;
  assign sp_pos = moving && !sp_neg;

  // End stop is taken when close to the extreme seen so far and driving toward it.
  assign hit_max = (CMP_W'(high_n) > CMP_W'(HIGH_END_LEVEL)) && sp_pos &&
                   (p_x + margin_x >= CMP_W'(high_n));
  assign hit_min = (CMP_W'(low_n) < CMP_W'(LOW_END_LEVEL)) && sp_neg &&
                   (p_x <= CMP_W'(low_n) + margin_x);

  assign low_o  = low_n;
  assign high_o = high_n;

  always_comb begin
    stat_o = stat_i;
    if (pos_delta <= CMP_W'(cfg_i.stall_win)) begin
      if (moving) begin
        stat_o.still_cnt = cnt_inc;
        if (cnt_inc >= cfg_i.cnt_limit) begin
          if (hit_max) begin
            stat_o.at_max    = 1'b1;
            stat_o.still_cnt = '0;
          end else if (hit_min) begin
            stat_o.at_min    = 1'b1;
            stat_o.still_cnt = '0;
          end else if (stat_i.err == ERR_NONE || stat_i.err == ERR_SYNC) begin
            stat_o.err = ERR_STILL;
          end
        end
      end
    end else begin
      stat_o.still_cnt = '0;
      if (stat_i.err == ERR_STILL) begin
        stat_o.err = ERR_NONE;
      end
      if (sp_neg) begin
        stat_o.at_max = 1'b0;
      end
      if (sp_pos) begin
        stat_o.at_min = 1'b0;
      end
    end
  end

endmodule

[hw/rtl/dasm_sync.sv]
// Pair synchronizer: slows the leading shoulder actuator as the position gap grows.
// Combinational, one constant multiplier for the 0.9 scaling; uses dasm_pkg.
module dasm_sync
  import dasm_pkg::*;
#(
  parameter int POS_W      = 10,
  parameter int CMP_W      = 14,
  parameter int SPEED_BITS = SPEED_BITS_DEF
) (
  input  cfg_t                          cfg_i,
  input  logic        [POS_W-1:0]       pos_a_i,
  input  logic        [POS_W-1:0]       pos_b_i,
  input  logic signed [SPEED_BITS-1:0]  speed_a_i,
  input  logic signed [SPEED_BITS-1:0]  speed_b_i,
  input  logic signed [SPEED_BITS-1:0]  target_i,
  output logic signed [SPEED_BITS-1:0]  speed_a_o,
  output logic signed [SPEED_BITS-1:0]  speed_b_o,
  output logic                          gap_over_small_o
);

  localparam int PROD_W = SPEED_BITS + 16;

  logic                         target_pos;
  logic                         lead_a;
  logic [CMP_W-1:0]             gap;
  logic                         over_large;
  logic                         over_mid;
  logic                         slow_lead;
  logic signed [SPEED_BITS-1:0] lead_ds;
  logic signed [SPEED_BITS-1:0] half_sum;
  logic signed [SPEED_BITS-1:0] half;
  logic signed [PROD_W-1:0]     prod;
  logic signed [PROD_W-1:0]     prod_adj;
  logic signed [SPEED_BITS-1:0] scaled;
  logic signed [SPEED_BITS-1:0] lead_new;

  assign target_pos = !target_i[SPEED_BITS-1] && (|target_i);
  // The leader is the one further out when extending, further in otherwise.
  assign lead_a  = target_pos ? (pos_a_i > pos_b_i) : (pos_a_i < pos_b_i);
  assign gap     = CMP_W'((pos_a_i >= pos_b_i) ? (pos_a_i - pos_b_i) : (pos_b_i - pos_a_i));
  assign lead_ds = lead_a ? speed_a_i : speed_b_i;

  // Halving and 0.9 scaling both round toward zero, so negative values get a bias.
  assign half_sum = lead_ds + $signed({{(SPEED_BITS-1){1'b0}}, lead_ds[SPEED_BITS-1]});
  assign half     = half_sum >>> 1;
  assign prod     = PROD_W'(lead_ds) * PROD_W'(NINE_TENTHS_Q15);
  assign prod_adj = prod + $signed({{(PROD_W-Q15_SHIFT){1'b0}},
                                    {Q15_SHIFT{prod[PROD_W-1]}}});
  assign scaled   = prod_adj[Q15_SHIFT +: SPEED_BITS];

  assign gap_over_small_o = gap > CMP_W'(cfg_i.thr_small);
  assign over_large       = gap > CMP_W'(cfg_i.thr_large);
  assign over_mid         = gap > CMP_W'(cfg_i.thr_mid);
  // The thresholds need not be ordered, so any one of them being passed slows the leader.
  assign slow_lead        = over_large || over_mid || gap_over_small_o;

  always_comb begin
    speed_a_o = speed_a_i;
    speed_b_o = speed_b_i;
    lead_new  = lead_ds;
    if (over_large) begin
      lead_new = '0;
    end else if (over_mid) begin
      lead_new = half;
    end else if (gap_over_small_o) begin
      lead_new = scaled;
    end
    if (slow_lead) begin
      if (lead_a) begin
        speed_a_o = lead_new;
      end else begin
        speed_b_o = lead_new;
      end
    end else begin
      speed_a_o = target_i;
      speed_b_o = target_i;
    end
  end

endmodule

[hw/rtl/dual_actuator_sync_stall_monitor_top.sv]
// Top level of the dual actuator sync and stall monitor.
// Instantiates dasm_track (three times) and dasm_sync; uses dasm_pkg.
//
// Usage: each input item is either a pot sample (three positions) or a speed
// command for the shoulder pair or for the dump actuator. Every accepted item
// yields one result item carrying the three drive speeds, the three error
// codes and the six end stop flags as they stand after that item.
// An item is taken into an input register; once no waiting result holds it,
// its whole update runs through one level of logic into the actuator state
// registers, which drive the result ports directly. Throughput is one item
// per cycle while out_stall is low, set by the single update stage and its
// one 0.9 multiplier. When out_stall holds a result, the input register
// still takes one more item; in_stall rises only once that register is full
// and the result is still waiting. Configuration is to be written through
// cfg_we/cfg_index/cfg_wdata only while no item is in flight; the user must
// ensure it; the block doesn't. After reset all errors read link lost, speeds
// are zero, the extremes are cleared and the registers take their defaults.
module dual_actuator_sync_stall_monitor_top
  import dasm_pkg::*;
#(
  parameter int POT_FULL_SCALE = POT_FULL_SCALE_DEF,
  parameter int SPEED_BITS     = SPEED_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [CMD_W-1:0]             in_cmd,
  input  logic signed [POT_W-1:0]      in_pot_a,
  input  logic signed [POT_W-1:0]      in_pot_b,
  input  logic signed [POT_W-1:0]      in_pot_c,
  input  logic signed [SPEED_BITS-1:0] in_speed_value,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SPEED_BITS-1:0] out_speed_a,
  output logic signed [SPEED_BITS-1:0] out_speed_b,
  output logic signed [SPEED_BITS-1:0] out_speed_c,
  output logic [ERR_W-1:0]             out_error_a,
  output logic [ERR_W-1:0]             out_error_b,
  output logic [ERR_W-1:0]             out_error_c,
  output logic                         out_at_max_a,
  output logic                         out_at_min_a,
  output logic                         out_at_max_b,
  output logic                         out_at_min_b,
  output logic                         out_at_max_c,
  output logic                         out_at_min_c
);

  localparam int POS_W  = $clog2(POT_FULL_SCALE);
  localparam int SEEN_W = POS_W + 1;
  localparam int CMP_W  = POS_W + 4;
  localparam int NACT   = 3;

  // ---------------------------------------------------------------- config
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO:       cfg_r.auto_en    <= cfg_wdata[0];
        CFG_THR_SMALL:  cfg_r.thr_small  <= cfg_wdata[THR_W-1:0];
        CFG_THR_MID:    cfg_r.thr_mid    <= cfg_wdata[THR_W-1:0];
        CFG_THR_LARGE:  cfg_r.thr_large  <= cfg_wdata[THR_W-1:0];
        CFG_STALL_WIN:  cfg_r.stall_win  <= cfg_wdata[WIN_W-1:0];
        CFG_CNT_LIMIT:  cfg_r.cnt_limit  <= cfg_wdata[CNT_W-1:0];
        CFG_END_MARGIN: cfg_r.end_margin <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input stage
  logic                         in_v_r;
  logic                         out_v_r;
  logic [CMD_W-1:0]             cmd_r;
  logic [POT_W-1:0]             pot_r [NACT];
  logic signed [SPEED_BITS-1:0] sv_r;
  logic                         advance;
  logic                         in_take;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r    <= in_cmd;
      pot_r[0] <= in_pot_a;
      pot_r[1] <= in_pot_b;
      pot_r[2] <= in_pot_c;
      sv_r     <= in_speed_value;
    end
  end

  // ---------------------------------------------------------------- state
  logic        [POS_W-1:0]      last_r     [NACT];
  logic        [POS_W-1:0]      last_nxt   [NACT];
  logic        [SEEN_W-1:0]     low_r      [NACT];
  logic        [SEEN_W-1:0]     low_nxt    [NACT];
  logic        [SEEN_W-1:0]     high_r     [NACT];
  logic        [SEEN_W-1:0]     high_nxt   [NACT];
  trk_stat_t                    stat_r     [NACT];
  trk_stat_t                    stat_nxt   [NACT];
  logic signed [SPEED_BITS-1:0] ds_r       [NACT];
  logic signed [SPEED_BITS-1:0] ds_nxt     [NACT];
  logic signed [SPEED_BITS-1:0] target_r;
  logic signed [SPEED_BITS-1:0] target_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NACT; k++) begin
        last_r[k] <= '0;
        low_r[k]  <= SEEN_W'(POT_FULL_SCALE);
        high_r[k] <= '0;
        stat_r[k] <= '{still_cnt: '0, err: ERR_LINK, at_max: 1'b0, at_min: 1'b0};
        ds_r[k]   <= '0;
      end
      target_r <= '0;
    end else if (advance) begin
      for (int k = 0; k < NACT; k++) begin
        last_r[k] <= last_nxt[k];
        low_r[k]  <= low_nxt[k];
        high_r[k] <= high_nxt[k];
        stat_r[k] <= stat_nxt[k];
        ds_r[k]   <= ds_nxt[k];
      end
      target_r <= target_nxt;
    end
  end

  // ------------------------------------------------------- pot decoding
  function automatic logic [POS_W-1:0] clamp_pot(input logic [POT_W-1:0] raw);
    logic [CMP_W-1:0] mag;
    mag = CMP_W'(raw[POT_W-2:0]);
    if (raw[POT_W-1]) begin
      return '0;
    end else if (mag > CMP_W'(POT_FULL_SCALE - 1)) begin
      return POS_W'(POT_FULL_SCALE - 1);
    end else begin
      return mag[POS_W-1:0];
    end
  endfunction

  function automatic logic pot_disc(input logic [POT_W-1:0] raw);
    return !raw[POT_W-1] && (CMP_W'(raw[POT_W-2:0]) == CMP_W'(POT_FULL_SCALE));
  endfunction

  function automatic logic pair_open(input err_code_t ea, input err_code_t eb);
    return ea != ERR_LINK && ea != ERR_POT && eb != ERR_POT;
  endfunction

  logic [POS_W-1:0] pos_c [NACT];
  err_code_t        e_lp  [NACT];
  logic             link_lost;
  logic             open_cur;
  logic             open_pot;

  assign link_lost = (pot_r[0] == {POT_W{1'b1}}) || (pot_r[1] == {POT_W{1'b1}});

  // Error codes after the link and disconnect checks of a pot sample.
  always_comb begin
    for (int k = 0; k < NACT; k++) begin
      e_lp[k] = stat_r[k].err;
    end
    if (link_lost) begin
      for (int k = 0; k < NACT; k++) begin
        e_lp[k] = ERR_LINK;
      end
    end else if (stat_r[0].err == ERR_LINK) begin
      for (int k = 0; k < NACT; k++) begin
        e_lp[k] = ERR_NONE;
      end
    end
    for (int k = 0; k < NACT; k++) begin
      if (pot_disc(pot_r[k])) begin
        e_lp[k] = ERR_POT;
      end else if (e_lp[k] == ERR_POT) begin
        e_lp[k] = ERR_NONE;
      end
    end
  end

  assign open_cur = pair_open(stat_r[0].err, stat_r[1].err);
  assign open_pot = pair_open(e_lp[0], e_lp[1]);

  // ------------------------------------------------------------ trackers
  trk_stat_t        trk_in   [NACT];
  trk_stat_t        trk_stat [NACT];
  logic [SEEN_W-1:0] trk_low  [NACT];
  logic [SEEN_W-1:0] trk_high [NACT];

  for (genvar g = 0; g < NACT; g++) begin : g_trk
    assign pos_c[g] = clamp_pot(pot_r[g]);

    always_comb begin
      trk_in[g]     = stat_r[g];
      trk_in[g].err = e_lp[g];
    end

    dasm_track #(
      .POS_W      (POS_W),
      .CMP_W      (CMP_W),
      .SPEED_BITS (SPEED_BITS)
    ) u_track (
      .cfg_i   (cfg_r),
      .pos_i   (pos_c[g]),
      .speed_i (ds_r[g]),
      .last_i  (last_r[g]),
      .low_i   (low_r[g]),
      .high_i  (high_r[g]),
      .stat_i  (trk_in[g]),
      .low_o   (trk_low[g]),
      .high_o  (trk_high[g]),
      .stat_o  (trk_stat[g])
    );
  end

  // ---------------------------------------------------------------- sync
  logic                         sel_pot;
  logic        [POS_W-1:0]      sync_pa;
  logic        [POS_W-1:0]      sync_pb;
  logic signed [SPEED_BITS-1:0] sync_ds_a;
  logic signed [SPEED_BITS-1:0] sync_ds_b;
  logic signed [SPEED_BITS-1:0] sync_target;
  logic signed [SPEED_BITS-1:0] sync_out_a;
  logic signed [SPEED_BITS-1:0] sync_out_b;
  logic                         gap_big;
  logic                         sv_pos;
  logic                         sv_neg;

  // A pot sample syncs on the new positions; a shoulder command on the stored
  // ones, with both speeds freshly set to the command.
  assign sel_pot     = (cmd_r == CMD_POT);
  assign sync_pa     = sel_pot ? pos_c[0] : last_r[0];
  assign sync_pb     = sel_pot ? pos_c[1] : last_r[1];
  assign sync_ds_a   = sel_pot ? ds_r[0] : sv_r;
  assign sync_ds_b   = sel_pot ? ds_r[1] : sv_r;
  assign sync_target = sel_pot ? target_r : sv_r;

  dasm_sync #(
    .POS_W      (POS_W),
    .CMP_W      (CMP_W),
    .SPEED_BITS (SPEED_BITS)
  ) u_sync (
    .cfg_i            (cfg_r),
    .pos_a_i          (sync_pa),
    .pos_b_i          (sync_pb),
    .speed_a_i        (sync_ds_a),
    .speed_b_i        (sync_ds_b),
    .target_i         (sync_target),
    .speed_a_o        (sync_out_a),
    .speed_b_o        (sync_out_b),
    .gap_over_small_o (gap_big)
  );

  assign sv_neg = sv_r[SPEED_BITS-1];
  assign sv_pos = !sv_neg && (|sv_r);

  // ---------------------------------------------------------- next state
  always_comb begin
    for (int k = 0; k < NACT; k++) begin
      last_nxt[k] = last_r[k];
      low_nxt[k]  = low_r[k];
      high_nxt[k] = high_r[k];
      stat_nxt[k] = stat_r[k];
      ds_nxt[k]   = ds_r[k];
    end
    target_nxt = target_r;

    case (cmd_r)
      CMD_POT: begin
        for (int k = 0; k < NACT; k++) begin
          stat_nxt[k].err = e_lp[k];
        end
        if (open_pot) begin
          for (int k = 0; k < 2; k++) begin
            last_nxt[k] = pos_c[k];
            low_nxt[k]  = trk_low[k];
            high_nxt[k] = trk_high[k];
            stat_nxt[k] = trk_stat[k];
            if (gap_big) begin
              if (trk_stat[k].err == ERR_NONE) begin
                stat_nxt[k].err = ERR_SYNC;
              end
            end else if (trk_stat[k].err == ERR_SYNC) begin
              stat_nxt[k].err = ERR_NONE;
            end
          end
          ds_nxt[0] = sync_out_a;
          ds_nxt[1] = sync_out_b;
        end
        if (e_lp[2] != ERR_LINK && e_lp[2] != ERR_POT) begin
          last_nxt[2] = pos_c[2];
          low_nxt[2]  = trk_low[2];
          high_nxt[2] = trk_high[2];
          stat_nxt[2] = trk_stat[2];
        end
      end
      CMD_SHOULDER: begin
        target_nxt = sv_r;
        if (!cfg_r.auto_en || open_cur) begin
          ds_nxt[0] = sv_r;
          ds_nxt[1] = sv_r;
        end
        if (open_cur) begin
          ds_nxt[0] = sync_out_a;
          ds_nxt[1] = sync_out_b;
          for (int k = 0; k < 2; k++) begin
            if ((stat_r[k].at_max && sv_pos) || (stat_r[k].at_min && sv_neg)) begin
              ds_nxt[k] = '0;
            end
          end
        end
      end
      CMD_DUMP: begin
        if (!cfg_r.auto_en) begin
          ds_nxt[2] = sv_r;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- results
  assign out_valid    = out_v_r;
  assign out_speed_a  = ds_r[0];
  assign out_speed_b  = ds_r[1];
  assign out_speed_c  = ds_r[2];
  assign out_error_a  = stat_r[0].err;
  assign out_error_b  = stat_r[1].err;
  assign out_error_c  = stat_r[2].err;
  assign out_at_max_a = stat_r[0].at_max;
  assign out_at_min_a = stat_r[0].at_min;
  assign out_at_max_b = stat_r[1].at_max;
  assign out_at_min_b = stat_r[1].at_min;
  assign out_at_max_c = stat_r[2].at_max;
  assign out_at_min_c = stat_r[2].at_min;

  // ---------------------------------------------------------- assertions
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed item did not produce a result");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled although no result is pending");

  a_dump_ignored_in_auto: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_DUMP && cfg_r.auto_en) |=> $stable(out_speed_c))
    else $error("dump speed changed in automation mode");

  // A disconnected first pot overrides the link loss on its own error code.
  a_link_lost_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_POT && link_lost && !pot_disc(pot_r[0]))
      |=> out_error_a == ERR_LINK)
    else $error("link loss not reported on first shoulder actuator");

endmodule
